// ===== design/spq_pkg.sv =====
// Shared types, codes and default sizes for the sorted priority queue.
package spq_pkg;

	localparam int DEPTH_DEF          = 16;
	localparam int PAYLOAD_WIDTH_DEF  = 32;
	localparam int PRIORITY_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Command broadcast to every cell of the chain at once.
	typedef struct packed {
		logic push;
		logic pop;
	} spq_ctrl_t;

endpackage

// ===== design/spq_cell.sv =====
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
module spq_cell #(
	parameter int PAYLOAD_WIDTH  = 32,
	parameter int PRIORITY_WIDTH = 32
) (
	input  logic                             clk,
	input  spq_pkg::spq_ctrl_t               ctrl,
	input  logic                             occupied,
	input  logic [PAYLOAD_WIDTH-1:0]         new_payload,
	input  logic signed [PRIORITY_WIDTH-1:0] new_priority,
	input  logic                             left_greater,
	input  logic [PAYLOAD_WIDTH-1:0]         left_payload,
	input  logic signed [PRIORITY_WIDTH-1:0] left_priority,
	input  logic [PAYLOAD_WIDTH-1:0]         right_payload,
	input  logic signed [PRIORITY_WIDTH-1:0] right_priority,
	output logic                             greater,
	output logic [PAYLOAD_WIDTH-1:0]         payload,
	output logic signed [PRIORITY_WIDTH-1:0] priority_val
);
	import spq_pkg::*;

	logic [PAYLOAD_WIDTH-1:0]         payload_q;
	logic signed [PRIORITY_WIDTH-1:0] priority_q;

	// Strictly greater entries stay put, so equal priorities end up behind the new one.
	assign greater      = occupied && (priority_q > new_priority);
	assign payload      = payload_q;
	assign priority_val = priority_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (!greater) begin
				if (left_greater) begin
					payload_q  <= new_payload;
					priority_q <= new_priority;
				end else begin
					payload_q  <= left_payload;
					priority_q <= left_priority;
				end
			end
		end else if (ctrl.pop) begin
			payload_q  <= right_payload;
			priority_q <= right_priority;
		end
	end

endmodule

// ===== design/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: cell chain, entry count and result register.
//
//   channel  direction  handshake            payload
//   in       into       in_valid / in_stall  operation, payload_in, priority_in
//   out      out of     out_valid/out_stall  payload_out, priority_out, status,
//                                            entry_count, is_empty
//
// Each accepted item has its result in the result register on the next cycle. Every
// cell compares against the broadcast priority in that same cycle, so a push, pop or
// peek needs no walk along the chain at any depth. A new item is taken whenever the
// result register is empty or being read. Reset clears the entry count and the result
// valid flag, not the result data; the cell contents need no reset. A stall on the
// output while a result is valid holds the result and stalls the input.
module sorted_priority_queue_top #(
	parameter int DEPTH          = spq_pkg::DEPTH_DEF,
	parameter int PAYLOAD_WIDTH  = spq_pkg::PAYLOAD_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF,
	localparam int CW            = $clog2(DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       operation,
	input  logic [PAYLOAD_WIDTH-1:0]         payload_in,
	input  logic signed [PRIORITY_WIDTH-1:0] priority_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [PAYLOAD_WIDTH-1:0]         payload_out,
	output logic signed [PRIORITY_WIDTH-1:0] priority_out,
	output logic [1:0]                       status,
	output logic [CW-1:0]                    entry_count,
	output logic                             is_empty
);
	import spq_pkg::*;

	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    count_d;
	logic                             out_valid_q;
	logic [PAYLOAD_WIDTH-1:0]         out_payload_q;
	logic signed [PRIORITY_WIDTH-1:0] out_priority_q;
	status_t                          out_status_q;
	logic [CW-1:0]                    out_count_q;

	logic                             accept;
	logic                             full;
	logic                             empty;
	spq_ctrl_t                        ctrl;
	status_t                          status_d;
	logic [PAYLOAD_WIDTH-1:0]         res_payload;
	logic signed [PRIORITY_WIDTH-1:0] res_priority;

	logic [PAYLOAD_WIDTH-1:0]         cell_payload  [DEPTH];
	logic signed [PRIORITY_WIDTH-1:0] cell_priority [DEPTH];
	logic                             cell_greater  [DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		ctrl         = '0;
		status_d     = ST_OK;
		count_d      = count_q;
		res_payload  = '0;
		res_priority = '0;
		case (operation)
			OP_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.push = accept;
					count_d   = count_q + CW'(1);
				end
			end
			OP_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.pop     = accept;
					count_d      = count_q - CW'(1);
					res_payload  = cell_payload[0];
					res_priority = cell_priority[0];
				end
			end
			default: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					res_payload  = cell_payload[0];
					res_priority = cell_priority[0];
				end
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                             left_gt;
		logic [PAYLOAD_WIDTH-1:0]         left_pay;
		logic signed [PRIORITY_WIDTH-1:0] left_pri;
		logic [PAYLOAD_WIDTH-1:0]         right_pay;
		logic signed [PRIORITY_WIDTH-1:0] right_pri;

		if (i == 0) begin : g_head
			assign left_gt  = 1'b1;
			assign left_pay = payload_in;
			assign left_pri = priority_in;
		end else begin : g_body
			assign left_gt  = cell_greater[i-1];
			assign left_pay = cell_payload[i-1];
			assign left_pri = cell_priority[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_pay = cell_payload[i];
			assign right_pri = cell_priority[i];
		end else begin : g_inner
			assign right_pay = cell_payload[i+1];
			assign right_pri = cell_priority[i+1];
		end

		spq_cell #(
			.PAYLOAD_WIDTH (PAYLOAD_WIDTH),
			.PRIORITY_WIDTH(PRIORITY_WIDTH)
		) u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.occupied      (count_q > CW'(i)),
			.new_payload   (payload_in),
			.new_priority  (priority_in),
			.left_greater  (left_gt),
			.left_payload  (left_pay),
			.left_priority (left_pri),
			.right_payload (right_pay),
			.right_priority(right_pri),
			.greater       (cell_greater[i]),
			.payload       (cell_payload[i]),
			.priority_val  (cell_priority[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_payload_q  <= res_payload;
			out_priority_q <= res_priority;
			out_status_q   <= status_d;
			out_count_q    <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_out  = out_payload_q;
	assign priority_out = out_priority_q;
	assign status       = out_status_q;
	assign entry_count  = out_count_q;
	assign is_empty     = (out_count_q == '0);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == ST_FULL) |-> out_count_q == CW'(DEPTH))
		else $error("full status reported below depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (operation == OP_PUSH) && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("accepted push did not add an entry");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q && out_count_q == count_q)
		else $error("result count differs from held entries");

endmodule

// ===== tb/sorted_priority_queue_top_test.sv =====
// Self-checking testbench for the sorted priority queue: directed corners, then random traffic.
module sorted_priority_queue_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int QDEPTH   = DEPTH_DEF;
	localparam int PW       = PAYLOAD_WIDTH_DEF;
	localparam int RW       = PRIORITY_WIDTH_DEF;
	localparam int CW       = $clog2(QDEPTH + 1);
	localparam int IDLE_PCT = 37;

	// The unused operation code; the block treats it as a peek.
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic signed [RW-1:0] PRIO_MAX = {1'b0, {(RW-1){1'b1}}};
	localparam logic signed [RW-1:0] PRIO_MIN = {1'b1, {(RW-1){1'b0}}};

	typedef struct {
		logic [PW-1:0]        payload;
		logic signed [RW-1:0] prio;
		status_t              st;
		logic [CW-1:0]        count;
		logic                 empty;
	} queue_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           operation;
	logic [PW-1:0]        payload_in;
	logic signed [RW-1:0] priority_in;
	logic                 out_valid;
	logic                 out_stall;
	logic [PW-1:0]        payload_out;
	logic signed [RW-1:0] priority_out;
	logic [1:0]           status;
	logic [CW-1:0]        entry_count;
	logic                 is_empty;

	// Shadow copy of the queue contents, head at index zero.
	logic [PW-1:0]        model_payloads [QDEPTH];
	logic signed [RW-1:0] model_prios [QDEPTH];
	int                   model_count;

	queue_result_t results_due[$];

	bit steady;
	int fail_count;
	int items_sent;
	int pushes_done;
	int full_refusals;
	int empty_reads;
	int results_checked;

	sorted_priority_queue_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.payload_in  (payload_in),
		.priority_in (priority_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.payload_out (payload_out),
		.priority_out(priority_out),
		.status      (status),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d results still outstanding.", results_due.size());
		$display("** sorted_priority_queue_top: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fail_count++;
	endtask

	// Applies one operation to the shadow queue and queues the result it must produce.
	function automatic void apply_queue_op(input logic [1:0] op, input logic [PW-1:0] pay,
			input logic signed [RW-1:0] prio);
		queue_result_t r;
		int            slot;
		int            i;
		r.payload = '0;
		r.prio    = '0;
		r.st      = ST_OK;
		if (op == OP_PUSH) begin
			if (model_count >= QDEPTH) begin
				r.st = ST_FULL;
				full_refusals++;
			end else begin
				// New entry goes behind strictly greater priorities, ahead of equal ones.
				slot = 0;
				while (slot < model_count && model_prios[slot] > prio)
					slot++;
				for (i = model_count; i > slot; i--) begin
					model_payloads[i] = model_payloads[i-1];
					model_prios[i]    = model_prios[i-1];
				end
				model_payloads[slot] = pay;
				model_prios[slot]    = prio;
				model_count++;
				pushes_done++;
			end
		end else if (model_count == 0) begin
			r.st = ST_EMPTY;
			empty_reads++;
		end else begin
			r.payload = model_payloads[0];
			r.prio    = model_prios[0];
			if (op == OP_POP) begin
				for (i = 1; i < model_count; i++) begin
					model_payloads[i-1] = model_payloads[i];
					model_prios[i-1]    = model_prios[i];
				end
				model_count--;
			end
		end
		r.count = CW'(model_count);
		r.empty = (model_count == 0);
		results_due.push_back(r);
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [PW-1:0] pay,
			input logic signed [RW-1:0] prio);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		payload_in  <= pay;
		priority_in <= prio;
		do
			@(posedge clk);
		while (in_stall);
		apply_queue_op(op, pay, prio);
		items_sent++;
	endtask

	task automatic random_item(input int push_pct);
		logic [1:0]           op;
		logic [PW-1:0]        pay;
		logic signed [RW-1:0] prio;
		int                   pick;
		if ($urandom_range(99) < push_pct)
			op = OP_PUSH;
		else begin
			pick = $urandom_range(9);
			op = (pick < 6) ? OP_POP : (pick < 9) ? OP_PEEK : OP_SPARE;
		end
		pick = $urandom_range(9);
		if (pick < 4)
			prio = RW'($signed($urandom_range(4)) - 2);   // crowd a few values to force ties
		else if (pick == 4) begin
			case ($urandom_range(3))
				0: prio = PRIO_MAX;
				1: prio = PRIO_MIN;
				2: prio = '0;
				default: prio = '1;
			endcase
		end else
			prio = $urandom;
		pick = $urandom_range(19);
		pay = (pick == 0) ? '0 : (pick == 1) ? '1 : PW'($urandom);
		send_item(op, pay, prio);
	endtask

	task automatic test_empty_queue;
		send_item(OP_POP, 32'hFFFF_FFFF, PRIO_MAX);
		send_item(OP_PEEK, 32'h0, PRIO_MIN);
		send_item(OP_SPARE, 32'h1234_5678, 32'sd0);
	endtask

	task automatic test_extreme_entries;
		send_item(OP_PUSH, 32'h0000_0000, PRIO_MAX);
		send_item(OP_PUSH, 32'hFFFF_FFFF, PRIO_MIN);
		send_item(OP_PUSH, 32'h5A5A_5A5A, 32'sd0);
		send_item(OP_PUSH, 32'hA5A5_A5A5, -32'sd1);
		// Ties: the newer entry must come out first.
		send_item(OP_PUSH, 32'h0000_0001, PRIO_MAX);
		send_item(OP_PUSH, 32'h0000_0002, PRIO_MIN);
		send_item(OP_PEEK, 32'h0, 32'sd0);
		send_item(OP_SPARE, 32'h0, 32'sd0);
		repeat (6)
			send_item(OP_POP, 32'hFFFF_FFFF, PRIO_MIN);
		send_item(OP_POP, 32'h0, 32'sd0);
	endtask

	// Segments alternate between filling, draining and balanced traffic so that both
	// the full and the empty boundary are crossed many times.
	task automatic test_random_traffic;
		int bias [8] = '{95, 50, 15, 85, 30, 97, 5, 60};
		foreach (bias[s])
			repeat (55)
				random_item(bias[s]);
	endtask

	task automatic test_steady_stream;
		steady = 1'b1;
		repeat (50) random_item(90);
		repeat (50) random_item(20);
		repeat (50) random_item(55);
		steady = 1'b0;
	endtask

	// The output side is driven from this block alone; it stays unchecked during reset.
	always @(posedge clk)
		out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin
		queue_result_t r;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0)
				report_mismatch("result arrived with none outstanding");
			else begin
				r = results_due.pop_front();
				results_checked++;
				if (payload_out !== r.payload)
					report_mismatch($sformatf("payload_out %h, wanted %h", payload_out, r.payload));
				if (priority_out !== r.prio)
					report_mismatch($sformatf("priority_out %0d, wanted %0d",
						priority_out, r.prio));
				if (status !== r.st)
					report_mismatch($sformatf("status %0d, wanted %s", status, r.st.name()));
				if (entry_count !== r.count)
					report_mismatch($sformatf("entry_count %0d, wanted %0d", entry_count, r.count));
				if (is_empty !== r.empty)
					report_mismatch($sformatf("is_empty %b, wanted %b", is_empty, r.empty));
			end
		end
	end

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		operation   <= OP_PUSH;
		payload_in  <= '0;
		priority_in <= '0;
		model_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_extreme_entries();
		test_random_traffic();
		test_steady_stream();
		in_valid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d items: %0d pushes stored, %0d refused as full, %0d reads on empty.",
			items_sent, pushes_done, full_refusals, empty_reads);
		$display("Checked %0d results, %0d mismatches.", results_checked, fail_count);
		if (fail_count == 0)
			$display("** sorted_priority_queue_top: PASSED **");
		else
			$display("** sorted_priority_queue_top: FAILED **");
		$finish;
	end

endmodule
